// File: sv/plb_pkg.sv
// Shared widths, request codes and types of the price level book.
package plb_pkg;

    localparam int LEVELS_DEFAULT = 64;
    localparam int PRICE_W        = 32;
    localparam int AMOUNT_W       = 31;
    localparam int STAMP_W        = 48;

    localparam logic [1:0] REQ_CLEAR    = 2'd0;
    localparam logic [1:0] REQ_SNAPSHOT = 2'd1;
    localparam logic [1:0] REQ_UPDATE   = 2'd2;

    localparam logic SIDE_ASK = 1'b0;
    localparam logic SIDE_BID = 1'b1;

    // One price level as held by a cell.
    typedef struct packed {
        logic                valid;
        logic [PRICE_W-1:0]  price;
        logic [AMOUNT_W-1:0] amount;
    } t_level;

    // Operation broadcast to every cell of one side.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ERASE,
        OP_OVERWRITE,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [PRICE_W-1:0]  price;
        logic [AMOUNT_W-1:0] amount;
    } t_cmd;

    // Request handed from the top level to one side.
    typedef struct packed {
        logic                active;
        logic                erase_on_zero;
        logic                clear;
        logic [PRICE_W-1:0]  price;
        logic [AMOUNT_W-1:0] amount;
    } t_side_req;

endpackage

// File: sv/plb_cell.sv
// One cell of a sorted level chain: holds a level, shifts to or from its neighbours.
module plb_cell
    import plb_pkg::*;
#(
    parameter bit IS_BID = 1'b0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  logic   i_left_before,
    input  t_level i_left,
    input  t_level i_right,
    output t_level o_level,
    output logic   o_before,
    output logic   o_equal
);

    logic                r_valid, n_valid;
    logic [PRICE_W-1:0]  r_price, n_price;
    logic [AMOUNT_W-1:0] r_amount, n_amount;

    // Held price sorts strictly ahead of the broadcast price.
    assign o_before = r_valid && (IS_BID ? (r_price > i_cmd.price) : (r_price < i_cmd.price));
    assign o_equal  = r_valid && (r_price == i_cmd.price);

    assign o_level.valid  = r_valid;
    assign o_level.price  = r_price;
    assign o_level.amount = r_amount;

    always_comb begin
        n_valid  = r_valid;
        n_price  = r_price;
        n_amount = r_amount;
        case (i_cmd.op)
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            OP_INSERT: begin
                if (!o_before) begin
                    if (i_left_before) begin
                        n_valid  = 1'b1;
                        n_price  = i_cmd.price;
                        n_amount = i_cmd.amount;
                    end else begin
                        n_valid  = i_left.valid;
                        n_price  = i_left.price;
                        n_amount = i_left.amount;
                    end
                end
            end
            OP_ERASE: begin
                if (!o_before) begin
                    n_valid  = i_right.valid;
                    n_price  = i_right.price;
                    n_amount = i_right.amount;
                end
            end
            OP_OVERWRITE: begin
                if (o_equal) begin
                    n_amount = i_cmd.amount;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_price  <= n_price;
        r_amount <= n_amount;
    end

endmodule

// File: sv/plb_side.sv
// One side of the book: decides the chain operation and holds the row of cells.
module plb_side
    import plb_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEFAULT,
    parameter bit IS_BID = 1'b0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_side_req i_req,
    output t_level    o_best,
    output logic      o_drop
);

    t_cmd   cmd;
    t_level levels [LEVELS];
    logic   ahead_v [LEVELS];
    logic   equal_v [LEVELS];
    logic   hit;
    logic   full;
    logic   zero_amount;

    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < LEVELS; k++) begin
            hit = hit | equal_v[k];
        end
    end

    assign full        = levels[LEVELS-1].valid;
    assign zero_amount = (i_req.amount == '0);

    always_comb begin
        cmd.op     = OP_HOLD;
        cmd.price  = i_req.price;
        cmd.amount = i_req.amount;
        o_drop     = 1'b0;
        if (i_req.clear) begin
            cmd.op = OP_CLEAR;
        end else if (i_req.active) begin
            if (hit) begin
                if (!zero_amount) begin
                    cmd.op = OP_OVERWRITE;
                end else if (i_req.erase_on_zero) begin
                    cmd.op = OP_ERASE;
                end
            end else if (!zero_amount) begin
                if (full) begin
                    o_drop = 1'b1;
                end else begin
                    cmd.op = OP_INSERT;
                end
            end
        end
    end

    for (genvar k = 0; k < LEVELS; k++) begin : g_cell
        t_level left_lv;
        t_level right_lv;
        logic   left_before;

        if (k == 0) begin : g_head
            assign left_before = 1'b1;
            assign left_lv     = '0;
        end else begin : g_body
            assign left_before = ahead_v[k-1];
            assign left_lv     = levels[k-1];
        end

        if (k == LEVELS - 1) begin : g_tail
            assign right_lv = '0;
        end else begin : g_inner
            assign right_lv = levels[k+1];
        end

        plb_cell #(
            .IS_BID (IS_BID)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_left_before (left_before),
            .i_left        (left_lv),
            .i_right       (right_lv),
            .o_level       (levels[k]),
            .o_before      (ahead_v[k]),
            .o_equal       (equal_v[k])
        );
    end

    assign o_best = levels[0];

endmodule

// File: sv/price_level_book_top.sv
// Top level of the price level book: request decode, two level chains, report register.
// Throughput: one item per clock cycle; busy is never raised and the receiver cannot stall.
// Latency: the report for an end-of-message item shows on the outputs in the cycle after
// the item is accepted, for one cycle, marked by o_strobe; every cell of a side compares
// and shifts in the same cycle, so no item waits on a search.
// Reset: synchronous, active low; both sides empty, stamp and overflow flag cleared.
module price_level_book_top
    import plb_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_req_type,
    input  logic                i_side,
    input  logic [PRICE_W-1:0]  i_price_ticks,
    input  logic [AMOUNT_W-1:0] i_quantity,
    input  logic [STAMP_W-1:0]  i_stamp,
    input  logic                i_end_of_message,
    output logic                o_strobe,
    output logic [STAMP_W-1:0]  o_report_stamp,
    output logic [PRICE_W-1:0]  o_bid_px,
    output logic [AMOUNT_W-1:0] o_bid_qty,
    output logic [PRICE_W-1:0]  o_ask_px,
    output logic [AMOUNT_W-1:0] o_ask_qty,
    output logic                o_bid_present,
    output logic                o_ask_present,
    output logic                o_overflowed
);

    logic               accept;
    logic               level_req;
    logic               erase_on_zero;
    logic               clear_req;
    t_side_req          ask_req;
    t_side_req          bid_req;
    t_level             ask_best;
    t_level             bid_best;
    logic               ask_drop;
    logic               bid_drop;

    logic               r_strobe, n_strobe;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic               r_drop_seen, n_drop_seen;
    logic               r_overflowed, n_overflowed;

    // Every cell updates in the same cycle, so the block is always ready for the next item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the request; the unused code touches no level but still takes the stamp.
    always_comb begin
        level_req     = 1'b0;
        erase_on_zero = 1'b0;
        clear_req     = 1'b0;
        case (i_req_type)
            REQ_CLEAR: begin
                clear_req = 1'b1;
            end
            REQ_SNAPSHOT: begin
                level_req = 1'b1;
            end
            REQ_UPDATE: begin
                level_req     = 1'b1;
                erase_on_zero = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign ask_req.active        = accept && level_req && (i_side == SIDE_ASK);
    assign ask_req.erase_on_zero = erase_on_zero;
    assign ask_req.clear         = accept && clear_req;
    assign ask_req.price         = i_price_ticks;
    assign ask_req.amount        = i_quantity;

    assign bid_req.active        = accept && level_req && (i_side == SIDE_BID);
    assign bid_req.erase_on_zero = erase_on_zero;
    assign bid_req.clear         = accept && clear_req;
    assign bid_req.price         = i_price_ticks;
    assign bid_req.amount        = i_quantity;

    // Asks sorted ascending, bids descending: cell 0 of each chain is the best level.
    plb_side #(
        .LEVELS (LEVELS),
        .IS_BID (1'b0)
    ) u_ask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ask_req),
        .o_best  (ask_best),
        .o_drop  (ask_drop)
    );

    plb_side #(
        .LEVELS (LEVELS),
        .IS_BID (1'b1)
    ) u_bid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bid_req),
        .o_best  (bid_best),
        .o_drop  (bid_drop)
    );

    // Take the stamp on every item; on end of message raise the strobe, report the
    // overflow flag including any drop by this item, and start a fresh drop record.
    always_comb begin
        n_strobe     = 1'b0;
        n_stamp      = r_stamp;
        n_drop_seen  = r_drop_seen;
        n_overflowed = r_overflowed;
        if (accept) begin
            n_stamp = i_stamp;
            if (i_end_of_message) begin
                n_strobe     = 1'b1;
                n_overflowed = r_drop_seen | ask_drop | bid_drop;
                n_drop_seen  = 1'b0;
            end else begin
                n_drop_seen = r_drop_seen | ask_drop | bid_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe     <= 1'b0;
            r_stamp      <= '0;
            r_drop_seen  <= 1'b0;
            r_overflowed <= 1'b0;
        end else begin
            r_strobe     <= n_strobe;
            r_stamp      <= n_stamp;
            r_drop_seen  <= n_drop_seen;
            r_overflowed <= n_overflowed;
        end
    end

    // The report reads the head cells directly; an empty side shows zeros.
    assign o_strobe       = r_strobe;
    assign o_report_stamp = r_stamp;
    assign o_bid_present  = bid_best.valid;
    assign o_ask_present  = ask_best.valid;
    assign o_bid_px       = bid_best.valid ? bid_best.price  : '0;
    assign o_bid_qty      = bid_best.valid ? bid_best.amount : '0;
    assign o_ask_px       = ask_best.valid ? ask_best.price  : '0;
    assign o_ask_qty      = ask_best.valid ? ask_best.amount : '0;
    assign o_overflowed   = r_overflowed;

endmodule
